// ----- rtl/frame_stack_allocator_assert.svh -----
// Assertion macros for the frame stack allocator.
// Needs clk and rst_n in the scope where a macro is used.
`ifndef FRAME_STACK_ALLOCATOR_ASSERT_SVH
`define FRAME_STACK_ALLOCATOR_ASSERT_SVH
`ifndef SYNTHESIS
// Same-cycle implication, checked outside reset.
`define FSA_ASSERT_NOW(lbl, cond, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (prop)) \
    else $error("frame stack allocator check failed");
// Next-cycle implication, checked outside reset.
`define FSA_ASSERT_NEXT(lbl, cond, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (prop)) \
    else $error("frame stack allocator check failed");
`else
`define FSA_ASSERT_NOW(lbl, cond, prop)
`define FSA_ASSERT_NEXT(lbl, cond, prop)
`endif
`endif

// ----- rtl/fsa_pkg.sv -----
// Shared types, codes and helpers for the frame stack allocator.
// No dependencies; every other source file but the assertion header imports this package.
`timescale 1ns / 1ps
package fsa_pkg;

  localparam int unsigned DEPTH_DEF = 4096;
  localparam int unsigned ADDR_W    = 48;
  localparam int unsigned EXT_W     = ADDR_W + 1;
  localparam int unsigned OUT_CNT_W = 13;
  localparam int unsigned CFG_IDX_W = 2;

  localparam logic [EXT_W-1:0] PAGE_MASK = EXT_W'(12'hFFF);
  localparam logic [EXT_W-1:0] PAGE_SIZE = EXT_W'(13'h1000);
  localparam logic [EXT_W-1:0] ADDR_TOP  = {1'b1, {ADDR_W{1'b0}}};

  // Input modes.
  localparam logic [1:0] MODE_REGION = 2'd0;
  localparam logic [1:0] MODE_ALLOC  = 2'd1;
  localparam logic [1:0] MODE_FREE   = 2'd2;

  // Result status codes.
  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_EMPTY = 2'd1;
  localparam logic [1:0] ST_FULL  = 2'd2;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_KERNEL_START = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_KERNEL_LIMIT = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_STORE_START  = 2'd2;

  // Classified command codes.
  localparam logic [1:0] OP_NOP    = 2'd0;
  localparam logic [1:0] OP_REGION = 2'd1;
  localparam logic [1:0] OP_ALLOC  = 2'd2;
  localparam logic [1:0] OP_FREE   = 2'd3;

  // Command queue depth.
  localparam int unsigned Q_DEPTH = 2;
  localparam int unsigned Q_PTR_W = $clog2(Q_DEPTH);

  // One classified command. For a region, a is the first frame and b the end;
  // for a free, a holds the returned address.
  typedef struct packed {
    logic [1:0]       op;
    logic [EXT_W-1:0] a;
    logic [EXT_W-1:0] b;
  } cmd_t;

  // Configuration registers.
  typedef struct packed {
    logic [ADDR_W-1:0] kernel_start;
    logic [ADDR_W-1:0] kernel_limit;
    logic [ADDR_W-1:0] store_start;
  } cfg_t;

  // Round an address up to the next 4 KiB boundary.
  function automatic logic [EXT_W-1:0] round_up_page(input logic [EXT_W-1:0] a);
    return (a + PAGE_MASK) & ~PAGE_MASK;
  endfunction

endpackage

// ----- rtl/fsa_front.sv -----
// Front end: accepts input words and turns them into queue commands.
// Depends on fsa_pkg.
`timescale 1ns / 1ps
module fsa_front (
  input  logic                      in_valid,
  output logic                      in_ready,
  input  logic [1:0]                in_mode,
  input  logic [fsa_pkg::ADDR_W-1:0] in_region_base,
  input  logic [fsa_pkg::ADDR_W-1:0] in_region_length,
  input  logic                      in_region_usable,
  input  logic [fsa_pkg::ADDR_W-1:0] in_free_addr,
  input  logic                      q_full,
  output logic                      q_push,
  output fsa_pkg::cmd_t             q_cmd
);
  import fsa_pkg::*;

  logic [EXT_W-1:0] base_ext;
  logic [EXT_W-1:0] end_sum;
  logic [EXT_W-1:0] end_clip;

  assign in_ready = !q_full;
  assign q_push   = in_valid && !q_full;

  // Region bounds: first frame rounded up, end clipped to the address space and rounded down.
  assign base_ext = {1'b0, in_region_base};
  assign end_sum  = base_ext + {1'b0, in_region_length};
  assign end_clip = (end_sum > ADDR_TOP) ? ADDR_TOP : end_sum;

  // Classify the word by its mode.
  always_comb begin
    q_cmd.op = OP_NOP;
    q_cmd.a  = round_up_page(base_ext);
    q_cmd.b  = end_clip & ~PAGE_MASK;
    case (in_mode)
      MODE_REGION: begin
        q_cmd.op = in_region_usable ? OP_REGION : OP_NOP;
      end
      MODE_ALLOC: begin
        q_cmd.op = OP_ALLOC;
      end
      MODE_FREE: begin
        q_cmd.op = OP_FREE;
        q_cmd.a  = {1'b0, in_free_addr};
      end
      default: begin
        q_cmd.op = OP_NOP;
      end
    endcase
  end

endmodule

// ----- rtl/fsa_cmd_fifo.sv -----
// Short command queue between the front end and the stack engine.
// Depends on fsa_pkg.
`timescale 1ns / 1ps
module fsa_cmd_fifo (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          push,
  input  fsa_pkg::cmd_t push_cmd,
  output logic          full,
  input  logic          pop,
  output fsa_pkg::cmd_t pop_cmd,
  output logic          empty
);
  import fsa_pkg::*;

  cmd_t               ent_r [Q_DEPTH];
  logic [Q_PTR_W-1:0] wr_ptr_r;
  logic [Q_PTR_W-1:0] rd_ptr_r;
  logic [Q_PTR_W:0]   fill_r;

  assign full    = (fill_r == (Q_PTR_W+1)'(Q_DEPTH));
  assign empty   = (fill_r == '0);
  assign pop_cmd = ent_r[rd_ptr_r];

  // Pointer and fill bookkeeping.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      fill_r   <= '0;
    end else begin
      if (push) wr_ptr_r <= wr_ptr_r + 1'b1;
      if (pop)  rd_ptr_r <= rd_ptr_r + 1'b1;
      if (push && !pop)      fill_r <= fill_r + 1'b1;
      else if (pop && !push) fill_r <= fill_r - 1'b1;
    end
  end

  // Entry storage.
  always_ff @(posedge clk) begin
    if (push) ent_r[wr_ptr_r] <= push_cmd;
  end

endmodule

// ----- rtl/fsa_back.sv -----
// Stack engine: frame store, stack count, region walk and result register.
// Depends on fsa_pkg.
`timescale 1ns / 1ps
module fsa_back #(
  parameter int unsigned DEPTH = fsa_pkg::DEPTH_DEF
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  fsa_pkg::cfg_t                cfg,
  input  logic                         q_empty,
  input  fsa_pkg::cmd_t                q_cmd,
  output logic                         q_pop,
  input  logic                         out_ready,
  output logic                         out_valid,
  output logic [fsa_pkg::ADDR_W-1:0]    out_frame_addr,
  output logic [1:0]                   out_status,
  output logic [fsa_pkg::OUT_CNT_W-1:0] out_free_count
);
  import fsa_pkg::*;

  localparam int unsigned CW = $clog2(DEPTH + 1);
  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam logic [EXT_W-1:0] STORE_BYTES = EXT_W'(DEPTH * 8);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_RUN  = 2'd1;
  localparam logic [1:0] S_DONE = 2'd2;

  logic [1:0]        state_r, state_nxt;
  logic [CW-1:0]     count_r, count_nxt;
  logic [EXT_W-1:0]  frame_r, frame_nxt;
  logic [EXT_W-1:0]  end_r, end_nxt;
  logic [1:0]        res_status_r, res_status_nxt;
  logic              res_mem_r, res_mem_nxt;

  logic [EXT_W-1:0]  klim_up_r;
  logic [EXT_W-1:0]  slim_r;
  logic [EXT_W-1:0]  slim_up_r;

  logic [ADDR_W-1:0] mem [DEPTH];
  logic [ADDR_W-1:0] rd_data_r;
  logic              wr_en;
  logic [ADDR_W-1:0] wr_data;
  logic              rd_en;
  logic [CW-1:0]     count_dec;

  logic              out_valid_r;
  logic [ADDR_W-1:0] out_frame_r;
  logic [1:0]        out_status_r;
  logic [CW-1:0]     out_count_r;
  logic              out_load;

  logic              stack_full;
  logic              in_kernel;
  logic              in_store;

  // Derived bounds of the reserved ranges, all registered from the configuration.
  always_ff @(posedge clk) begin
    klim_up_r <= round_up_page({1'b0, cfg.kernel_limit});
    slim_r    <= {1'b0, cfg.store_start} + STORE_BYTES;
    slim_up_r <= round_up_page({1'b0, cfg.store_start} + STORE_BYTES);
  end

  assign stack_full = (count_r >= CW'(DEPTH));
  assign count_dec  = count_r - CW'(1);
  assign in_kernel  = (frame_r >= {1'b0, cfg.kernel_start}) &&
                      (frame_r <  {1'b0, cfg.kernel_limit});
  assign in_store   = (frame_r >= {1'b0, cfg.store_start}) && (frame_r < slim_r);
  assign out_load   = (state_r == S_DONE) && (!out_valid_r || out_ready);

  // Sequencer: take one command, walk a region one frame a cycle, then post the result.
  always_comb begin
    state_nxt      = state_r;
    count_nxt      = count_r;
    frame_nxt      = frame_r;
    end_nxt        = end_r;
    res_status_nxt = res_status_r;
    res_mem_nxt    = res_mem_r;
    q_pop          = 1'b0;
    wr_en          = 1'b0;
    wr_data        = frame_r[ADDR_W-1:0];
    rd_en          = 1'b0;
    case (state_r)
      S_IDLE: begin
        if (!q_empty) begin
          q_pop          = 1'b1;
          res_status_nxt = ST_OK;
          res_mem_nxt    = 1'b0;
          state_nxt      = S_DONE;
          case (q_cmd.op)
            OP_REGION: begin
              frame_nxt = q_cmd.a;
              end_nxt   = q_cmd.b;
              state_nxt = S_RUN;
            end
            OP_ALLOC: begin
              if (count_r == '0) begin
                res_status_nxt = ST_EMPTY;
              end else begin
                rd_en       = 1'b1;
                res_mem_nxt = 1'b1;
                count_nxt   = count_dec;
              end
            end
            OP_FREE: begin
              if (stack_full) begin
                res_status_nxt = ST_FULL;
              end else begin
                wr_en     = 1'b1;
                wr_data   = q_cmd.a[ADDR_W-1:0];
                count_nxt = count_r + CW'(1);
              end
            end
            default: begin
              res_status_nxt = ST_OK;
            end
          endcase
        end
      end
      S_RUN: begin
        if (frame_r >= end_r) begin
          res_status_nxt = ST_OK;
          state_nxt      = S_DONE;
        end else if (in_kernel) begin
          frame_nxt = klim_up_r;
        end else if (in_store) begin
          frame_nxt = slim_up_r;
        end else if (stack_full) begin
          res_status_nxt = ST_FULL;
          state_nxt      = S_DONE;
        end else begin
          wr_en     = 1'b1;
          count_nxt = count_r + CW'(1);
          frame_nxt = frame_r + PAGE_SIZE;
        end
      end
      S_DONE: begin
        if (out_load) state_nxt = S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      count_r <= '0;
    end else begin
      state_r <= state_nxt;
      count_r <= count_nxt;
    end
  end

  // Walk and result holding registers.
  always_ff @(posedge clk) begin
    frame_r      <= frame_nxt;
    end_r        <= end_nxt;
    res_status_r <= res_status_nxt;
    res_mem_r    <= res_mem_nxt;
  end

  // Frame store: one write port at the top of stack, one registered read port.
  always_ff @(posedge clk) begin
    if (wr_en) mem[count_r[AW-1:0]] <= wr_data;
    if (rd_en) rd_data_r <= mem[count_dec[AW-1:0]];
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_frame_r  <= res_mem_r ? rd_data_r : '0;
      out_status_r <= res_status_r;
      out_count_r  <= count_r;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_frame_addr = out_frame_r;
  assign out_status     = out_status_r;
  assign out_free_count = OUT_CNT_W'(out_count_r);

endmodule

// ----- rtl/frame_stack_allocator.sv -----
// Free 4 KiB frame stack. Each word goes through the command queue, the engine's idle and
// done states and the output register; a region word also walks the run state, pushing
// one frame or skipping one reserved range per step. The engine takes no new word until
// its done state posts the result; a 2-entry command queue lets input run ahead.
// Synchronous active-low reset clears the count, queue, sequencer and configuration;
// the frame store is not cleared and needs no clearing pass.
`timescale 1ns / 1ps
`include "frame_stack_allocator_assert.svh"
module frame_stack_allocator #(
  parameter int unsigned DEPTH = fsa_pkg::DEPTH_DEF
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic [1:0]                   in_mode,
  input  logic [fsa_pkg::ADDR_W-1:0]    in_region_base,
  input  logic [fsa_pkg::ADDR_W-1:0]    in_region_length,
  input  logic                         in_region_usable,
  input  logic [fsa_pkg::ADDR_W-1:0]    in_free_addr,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic [fsa_pkg::ADDR_W-1:0]    out_frame_addr,
  output logic [1:0]                   out_status,
  output logic [fsa_pkg::OUT_CNT_W-1:0] out_free_count,
  input  logic                         cfg_we,
  input  logic [fsa_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [fsa_pkg::ADDR_W-1:0]    cfg_data
);
  import fsa_pkg::*;

  cfg_t cfg_r;
  cmd_t front_cmd;
  cmd_t q_cmd;
  logic q_push;
  logic q_full;
  logic q_pop;
  logic q_empty;

  // Configuration registers; writes to unused indexes are ignored.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_KERNEL_START: cfg_r.kernel_start <= cfg_data;
        CFG_KERNEL_LIMIT: cfg_r.kernel_limit <= cfg_data;
        CFG_STORE_START:  cfg_r.store_start  <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  // Front end classifies each input word.
  fsa_front u_front (
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_mode          (in_mode),
    .in_region_base   (in_region_base),
    .in_region_length (in_region_length),
    .in_region_usable (in_region_usable),
    .in_free_addr     (in_free_addr),
    .q_full           (q_full),
    .q_push           (q_push),
    .q_cmd            (front_cmd)
  );

  // Command queue.
  fsa_cmd_fifo u_fifo (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (q_push),
    .push_cmd (front_cmd),
    .full     (q_full),
    .pop      (q_pop),
    .pop_cmd  (q_cmd),
    .empty    (q_empty)
  );

  // Stack engine.
  fsa_back #(
    .DEPTH (DEPTH)
  ) u_back (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg            (cfg_r),
    .q_empty        (q_empty),
    .q_cmd          (q_cmd),
    .q_pop          (q_pop),
    .out_ready      (out_ready),
    .out_valid      (out_valid),
    .out_frame_addr (out_frame_addr),
    .out_status     (out_status),
    .out_free_count (out_free_count)
  );

  // An empty allocation returns address zero and an empty stack.
  `FSA_ASSERT_NOW(a_empty, out_valid && out_status == ST_EMPTY, ~|{out_frame_addr, out_free_count})
  // A full status is only reported with the stack at its depth.
  `FSA_ASSERT_NOW(a_full, out_valid && out_status == ST_FULL, out_free_count == OUT_CNT_W'(DEPTH))
  // The engine never pops an empty queue.
  `FSA_ASSERT_NOW(a_pop_nonempty, q_pop, !q_empty)
  // The engine never pops the queue back to back.
  `FSA_ASSERT_NEXT(a_pop_spacing, q_pop, !q_pop)

endmodule

// ----- tb/testbench.sv -----
// Self-checking testbench for the frame stack allocator: directed table, then random phases.
// Depends on fsa_pkg and the frame_stack_allocator RTL; reads no files.
`timescale 1ns / 1ps
module testbench;
  import fsa_pkg::*;

  localparam int unsigned STACK_DEPTH = DEPTH_DEF;
  localparam int          STALL_LIMIT = 20000;
  localparam logic [1:0]  MODE_SPARE  = 2'd3;
  localparam logic [63:0] FRAME_MASK  = 64'hFFF;
  localparam logic [63:0] FRAME_BYTES = 64'h1000;
  localparam logic [63:0] ADDR_SPAN   = 64'h1_0000_0000_0000;
  localparam logic [63:0] STORE_BYTES = 64'(STACK_DEPTH) * 64'd8;
  localparam logic [ADDR_W-1:0] ALL_ONES = {ADDR_W{1'b1}};

  typedef enum logic [1:0] {MIX_GROW, MIX_SHRINK, MIX_FILL} mix_t;

  typedef struct packed {
    logic [1:0]        mode;
    logic [ADDR_W-1:0] base;
    logic [ADDR_W-1:0] len;
    logic              usable;
    logic [ADDR_W-1:0] addr;
  } word_t;

  typedef struct packed {
    logic [ADDR_W-1:0]    frame;
    logic [1:0]           status;
    logic [OUT_CNT_W-1:0] count;
  } result_t;

  typedef struct packed {
    word_t   w;
    logic    pinned;
    result_t want;
  } row_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic [1:0] in_mode = MODE_REGION;
  logic [ADDR_W-1:0] in_region_base = '0;
  logic [ADDR_W-1:0] in_region_length = '0;
  logic in_region_usable = 1'b0;
  logic [ADDR_W-1:0] in_free_addr = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic [ADDR_W-1:0] out_frame_addr;
  logic [1:0] out_status;
  logic [OUT_CNT_W-1:0] out_free_count;
  logic cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = CFG_KERNEL_START;
  logic [ADDR_W-1:0] cfg_data = '0;

  // Shadow of the free frame stack and the reserved windows.
  logic [ADDR_W-1:0] stack_mem [STACK_DEPTH];
  int unsigned stack_top = 0;
  logic [ADDR_W-1:0] win_kernel_start = '0;
  logic [ADDR_W-1:0] win_kernel_limit = '0;
  logic [ADDR_W-1:0] win_store_start = '0;

  result_t pending_results [$];
  row_t    directed_rows [$];
  int      error_count = 0;
  int      stall_cycles = 0;
  logic    steady = 1'b0;

  frame_stack_allocator dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_mode         (in_mode),
    .in_region_base  (in_region_base),
    .in_region_length(in_region_length),
    .in_region_usable(in_region_usable),
    .in_free_addr    (in_free_addr),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_frame_addr  (out_frame_addr),
    .out_status      (out_status),
    .out_free_count  (out_free_count),
    .cfg_we          (cfg_we),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data)
  );

  initial begin
    forever #2 clk = ~clk;
  end

  function automatic logic [63:0] page_up(input logic [63:0] a);
    return (a + FRAME_MASK) & ~FRAME_MASK;
  endfunction

  // Push every usable frame of a region, skipping both reserved windows.
  function automatic logic [1:0] push_region(input logic [ADDR_W-1:0] base,
                                             input logic [ADDR_W-1:0] len);
    logic [63:0] frame;
    logic [63:0] stop;
    logic [63:0] store_end;
    frame = page_up(64'(base));
    stop = 64'(base) + 64'(len);
    store_end = 64'(win_store_start) + STORE_BYTES;
    if (stop > ADDR_SPAN) stop = ADDR_SPAN;
    stop = stop & ~FRAME_MASK;
    while (frame < stop) begin
      if (frame >= 64'(win_kernel_start) && frame < 64'(win_kernel_limit)) begin
        frame = page_up(64'(win_kernel_limit));
        continue;
      end
      if (frame >= 64'(win_store_start) && frame < store_end) begin
        frame = page_up(store_end);
        continue;
      end
      if (stack_top >= STACK_DEPTH) return ST_FULL;
      stack_mem[stack_top] = frame[ADDR_W-1:0];
      stack_top++;
      frame = frame + FRAME_BYTES;
    end
    return ST_OK;
  endfunction

  // Work out the result word of one input word and advance the shadow stack.
  function automatic result_t next_result(input word_t w);
    result_t r;
    r = '0;
    case (w.mode)
      MODE_REGION: begin
        if (w.usable) r.status = push_region(w.base, w.len);
      end
      MODE_ALLOC: begin
        if (stack_top == 0) begin
          r.status = ST_EMPTY;
        end else begin
          stack_top--;
          r.frame = stack_mem[stack_top];
        end
      end
      MODE_FREE: begin
        if (stack_top < STACK_DEPTH) begin
          stack_mem[stack_top] = w.addr;
          stack_top++;
        end else begin
          r.status = ST_FULL;
        end
      end
      default: ;
    endcase
    r.count = OUT_CNT_W'(stack_top);
    return r;
  endfunction

  function automatic logic [ADDR_W-1:0] rand48();
    logic [63:0] v;
    v = {$urandom, $urandom};
    return v[ADDR_W-1:0];
  endfunction

  function automatic word_t mk(input logic [1:0] mode, input logic [ADDR_W-1:0] base,
                               input logic [ADDR_W-1:0] len, input logic usable,
                               input logic [ADDR_W-1:0] addr);
    word_t w;
    w.mode = mode;
    w.base = base;
    w.len = len;
    w.usable = usable;
    w.addr = addr;
    return w;
  endfunction

  function automatic row_t pinned_row(input word_t w, input logic [ADDR_W-1:0] frame,
                                      input logic [1:0] status,
                                      input int count);
    row_t r;
    r.w = w;
    r.pinned = 1'b1;
    r.want.frame = frame;
    r.want.status = status;
    r.want.count = OUT_CNT_W'(count);
    return r;
  endfunction

  function automatic row_t modeled_row(input word_t w);
    row_t r;
    r.w = w;
    r.pinned = 1'b0;
    r.want = '0;
    return r;
  endfunction

  // Random word: mostly regions around the phase's zone, allocs and frees, plus noise.
  function automatic word_t random_word(input mix_t mix, input logic [ADDR_W-1:0] zone,
                                        input logic huge_ok);
    word_t w;
    int pick;
    int region_cut;
    int free_cut;
    w = mk(2'($urandom), rand48(), rand48(), 1'($urandom), rand48());
    pick = $urandom_range(0, 99);
    region_cut = (mix == MIX_GROW) ? 40 : (mix == MIX_SHRINK) ? 12 : 30;
    free_cut = (mix == MIX_GROW) ? 15 : (mix == MIX_SHRINK) ? 13 : 25;
    if (pick < region_cut) begin
      w.mode = MODE_REGION;
      w.usable = 1'b1;
      w.base = zone + ADDR_W'($urandom_range(0, 32'hFFFFF));
      if ($urandom_range(0, 3) == 0) w.base[11:0] = '0;
      if (mix == MIX_FILL) w.len = ADDR_W'($urandom_range(0, 32'h0200_0000));
      else if (huge_ok && $urandom_range(0, 9) == 0) w.len = ALL_ONES;
      else if ($urandom_range(0, 19) == 0) w.len = ADDR_W'($urandom_range(0, 32'h40000));
      else w.len = ADDR_W'($urandom_range(0, 32'h8000));
    end else if (pick < region_cut + 2) begin
      // Anywhere in the address space, but short.
      w.mode = MODE_REGION;
      w.usable = 1'b1;
      w.len = ADDR_W'($urandom_range(0, 32'h10000));
    end else if (pick < region_cut + 7) begin
      w.mode = MODE_REGION;
      w.usable = 1'b0;
    end else if (pick < region_cut + 12) begin
      w.mode = MODE_SPARE;
    end else if (pick < region_cut + 12 + free_cut) begin
      w.mode = MODE_FREE;
    end else begin
      w.mode = MODE_ALLOC;
    end
    return w;
  endfunction

  task automatic flag_error(input string msg);
    $display("ERROR at %0t ns: %s", $time, msg);
    error_count++;
  endtask

  // Offer one word, hold it until accepted, then record its expected result.
  task automatic send_word(input row_t row);
    result_t modeled;
    while (!steady && $urandom_range(0, 99) < 10) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_mode <= row.w.mode;
    in_region_base <= row.w.base;
    in_region_length <= row.w.len;
    in_region_usable <= row.w.usable;
    in_free_addr <= row.w.addr;
    do @(posedge clk); while (!in_ready);
    modeled = next_result(row.w);
    pending_results.push_back(row.pinned ? row.want : modeled);
  endtask

  // Stop sending and let every outstanding word come back.
  task automatic wait_idle();
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic load_windows(input logic [ADDR_W-1:0] ks, input logic [ADDR_W-1:0] kl,
                              input logic [ADDR_W-1:0] ss);
    cfg_we <= 1'b1;
    cfg_index <= CFG_KERNEL_START;
    cfg_data <= ks;
    @(posedge clk);
    cfg_index <= CFG_KERNEL_LIMIT;
    cfg_data <= kl;
    @(posedge clk);
    cfg_index <= CFG_STORE_START;
    cfg_data <= ss;
    @(posedge clk);
    cfg_we <= 1'b0;
    win_kernel_start = ks;
    win_kernel_limit = kl;
    win_store_start = ss;
  endtask

  // Result checker; the receiver stalls at random outside the steady phase.
  always @(posedge clk) begin
    result_t want;
    if (rst_n && out_valid && out_ready) begin
      if (pending_results.size() == 0) begin
        flag_error("result word with nothing outstanding");
      end else begin
        want = pending_results.pop_front();
        if (out_frame_addr !== want.frame)
          flag_error($sformatf("frame_addr got %h want %h", out_frame_addr, want.frame));
        if (out_status !== want.status)
          flag_error($sformatf("status got %0d want %0d", out_status, want.status));
        if (out_free_count !== want.count)
          flag_error($sformatf("free_count got %0d want %0d", out_free_count, want.count));
      end
    end
    out_ready <= steady || ($urandom_range(0, 99) >= 10);
  end

  // Watchdog on cycles without any handshake.
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) stall_cycles <= 0;
    else stall_cycles <= stall_cycles + 1;
    if (stall_cycles >= STALL_LIMIT) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  initial begin
    logic [ADDR_W-1:0] ks;
    logic [ADDR_W-1:0] kl;
    logic [ADDR_W-1:0] ss;
    logic [ADDR_W-1:0] zone;
    mix_t mix;
    logic huge_ok;
    int i;
    int p;

    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    // Directed rows, run with the reset windows: no kernel range, store at [0, 0x8000).
    directed_rows.push_back(pinned_row(mk(MODE_ALLOC, '0, '0, 1'b0, '0), '0, ST_EMPTY, 0));
    directed_rows.push_back(pinned_row(mk(MODE_SPARE, ALL_ONES, ALL_ONES, 1'b1, ALL_ONES),
                                       '0, ST_OK, 0));
    directed_rows.push_back(pinned_row(mk(MODE_REGION, 48'h10000, 48'h10000, 1'b0, '0),
                                       '0, ST_OK, 0));
    // Region that falls entirely inside the stack store window.
    directed_rows.push_back(modeled_row(mk(MODE_REGION, 48'h1001, 48'h3000, 1'b1, '0)));
    // Nothing left once base and end are rounded.
    directed_rows.push_back(pinned_row(mk(MODE_REGION, 48'h20001, 48'hFFE, 1'b1, '0),
                                       '0, ST_OK, 0));
    directed_rows.push_back(pinned_row(mk(MODE_REGION, 48'h30000, '0, 1'b1, '0),
                                       '0, ST_OK, 0));
    directed_rows.push_back(pinned_row(mk(MODE_REGION, 48'h10000, 48'h3000, 1'b1, '0),
                                       '0, ST_OK, 3));
    directed_rows.push_back(pinned_row(mk(MODE_ALLOC, '0, '0, 1'b0, '0),
                                       48'h12000, ST_OK, 2));
    directed_rows.push_back(pinned_row(mk(MODE_FREE, '0, '0, 1'b0, ALL_ONES), '0, ST_OK, 3));
    directed_rows.push_back(pinned_row(mk(MODE_ALLOC, '0, '0, 1'b0, '0), ALL_ONES, ST_OK, 2));
    directed_rows.push_back(pinned_row(mk(MODE_FREE, ALL_ONES, ALL_ONES, 1'b1, '0),
                                       '0, ST_OK, 3));
    directed_rows.push_back(pinned_row(mk(MODE_ALLOC, ALL_ONES, ALL_ONES, 1'b1, ALL_ONES),
                                       '0, ST_OK, 2));
    // End past the top of the address space is clipped.
    directed_rows.push_back(modeled_row(mk(MODE_REGION, 48'hFFFF_FFFF_F000, ALL_ONES, 1'b1,
                                           '0)));
    directed_rows.push_back(modeled_row(mk(MODE_ALLOC, '0, '0, 1'b0, '0)));
    directed_rows.push_back(modeled_row(mk(MODE_REGION, ALL_ONES, ALL_ONES, 1'b1, '0)));
    // Region overlapping the store window: only the frames above it are pushed.
    directed_rows.push_back(modeled_row(mk(MODE_REGION, '0, 48'h10000, 1'b1, '0)));
    directed_rows.push_back(modeled_row(mk(MODE_FREE, '0, '0, 1'b0, 48'h123)));
    directed_rows.push_back(modeled_row(mk(MODE_ALLOC, '0, '0, 1'b0, '0)));
    directed_rows.push_back(modeled_row(mk(MODE_REGION, ALL_ONES, ALL_ONES, 1'b0, ALL_ONES)));
    directed_rows.push_back(modeled_row(mk(MODE_SPARE, '0, '0, 1'b0, '0)));
    directed_rows.push_back(modeled_row(mk(MODE_ALLOC, '0, '0, 1'b0, '0)));
    directed_rows.push_back(modeled_row(mk(MODE_ALLOC, '0, '0, 1'b0, '0)));
    for (i = 0; i < directed_rows.size(); i++) send_word(directed_rows[i]);

    // Random phases, each with its own window setting; the last one fills the stack.
    for (p = 0; p < 7; p++) begin
      wait_idle();
      huge_ok = 1'b0;
      zone = 48'h1C0000;
      case (p)
        0: begin
          ks = 48'h200000; kl = 48'h240000; ss = 48'h250000; mix = MIX_GROW;
        end
        1: begin
          // Kernel window covers everything; store window sits at the very top.
          ks = '0; kl = ALL_ONES; ss = ALL_ONES; zone = 48'h1000_0000; mix = MIX_SHRINK;
        end
        2: begin
          // Inverted kernel window and an unaligned store start.
          ks = 48'h500000; kl = 48'h400000; ss = 48'h400800; zone = 48'h3F0000;
          mix = MIX_GROW;
        end
        3: begin
          // Overlapping windows with an unaligned kernel limit.
          ks = 48'h600000; kl = 48'h680123; ss = 48'h67C000; zone = 48'h5E0000;
          mix = MIX_SHRINK;
        end
        4: begin
          ks = 48'hFFFF_FFF8_0000; kl = ALL_ONES; ss = '0; zone = 48'hFFFF_FFF0_0000;
          mix = MIX_GROW; huge_ok = 1'b1;
        end
        5: begin
          zone = rand48() & 48'hFFFF_FFF0_0000;
          ks = zone + ADDR_W'($urandom_range(0, 32'hFFFFF));
          kl = ks + ADDR_W'($urandom_range(0, 32'h80000)) - ADDR_W'(32'h10000);
          ss = zone + ADDR_W'($urandom_range(0, 32'hFFFFF));
          mix = MIX_SHRINK;
        end
        default: begin
          ks = '0; kl = '0; ss = '0; zone = 48'h1_0000_0000; mix = MIX_FILL;
        end
      endcase
      load_windows(ks, kl, ss);
      steady <= (p == 2);
      for (i = 0; i < 200; i++) begin
        send_word(modeled_row(random_word(mix, zone, huge_ok)));
        if ($urandom_range(0, 149) == 0) wait_idle();
      end
    end

    // Drain, then give any stray result words time to show up.
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (error_count == 0) $display("*** PASSED ***");
    else $display("*** FAILED ***");
    $finish;
  end

endmodule

// ----- sim.f -----
+incdir+rtl
rtl/fsa_pkg.sv
rtl/fsa_front.sv
rtl/fsa_cmd_fifo.sv
rtl/fsa_back.sv
rtl/frame_stack_allocator.sv
tb/testbench.sv
